FILE: hw/rtl/aiec_pkg.sv
// Shared constants and types for the accelerometer impact event counter.
// No dependencies; every other file of the block refers to this package.

package aiec_pkg;

   // Axis codes of the request
   localparam int AXIS_BITS = 2;
   localparam logic [AXIS_BITS-1:0] AXIS_X = 2'd0;
   localparam logic [AXIS_BITS-1:0] AXIS_Y = 2'd1;
   localparam logic [AXIS_BITS-1:0] AXIS_Z = 2'd2;
   localparam int AXIS_COUNT = 3;

   // Register indexes of the configuration port
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS = 16;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_IMPACT_THRESHOLD = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_OVER_LIMIT = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WARMUP_TRIPLES = 2'd2;

   // Register widths and reset values
   localparam int THRESHOLD_BITS = 16;
   localparam int OVER_LIMIT_BITS = 8;
   localparam int WARMUP_BITS = 7;
   localparam logic [THRESHOLD_BITS-1:0] THRESHOLD_RESET = 16'd1000;
   localparam logic [OVER_LIMIT_BITS-1:0] OVER_LIMIT_RESET = 8'd3;
   localparam logic [WARMUP_BITS-1:0] WARMUP_RESET = 7'd100;

   // Counters
   localparam int COUNT_BITS = 16;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = 16'hFFFF;
   localparam int OVER_COUNT_BITS = OVER_LIMIT_BITS + 1;
   localparam logic [OVER_COUNT_BITS-1:0] OVER_COUNT_CEILING = 9'd256;

   // Low-pass filter step: lp += (target - lp) / FILTER_DIVISOR
   localparam int FILTER_DIVISOR = 10;

   // Control that travels with each request down the pipeline
   typedef struct packed {
      logic valid;
      logic search;
   } stage_ctl_type;

endpackage

FILE: hw/rtl/aiec_ifs.sv
// Channel interfaces of the impact event counter: request, response and
// register write. Depends on aiec_pkg for field widths.

interface aiec_req_if #(
   parameter int SAMPLE_BITS = 16
) ();
   logic                                 valid;
   logic                                 ready;
   logic signed [SAMPLE_BITS-1:0]        sample;
   logic [aiec_pkg::AXIS_BITS-1:0]       axis;
   logic                                 no_reading;

   modport source (output valid, sample, axis, no_reading, input ready);
   modport sink (input valid, sample, axis, no_reading, output ready);
endinterface

interface aiec_rsp_if ();
   logic                                 valid;
   logic                                 ready;
   logic [aiec_pkg::COUNT_BITS-1:0]      impact_count;
   logic                                 new_impact;

   modport source (output valid, impact_count, new_impact, input ready);
   modport sink (input valid, impact_count, new_impact, output ready);
endinterface

interface aiec_csr_if ();
   logic                                 valid;
   logic                                 ready;
   logic [aiec_pkg::CSR_INDEX_BITS-1:0]  index;
   logic [aiec_pkg::CSR_DATA_BITS-1:0]   data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

FILE: hw/rtl/aiec_filter.sv
// Triple assembly, low-pass filter update and warm-up count.
// Produces per-axis deviation magnitudes; depends on aiec_pkg.

module aiec_filter #(
   parameter int SAMPLE_BITS = 16,
   parameter int FILTER_FRACTION_BITS = 8,
   parameter int DEV_BITS = SAMPLE_BITS + FILTER_FRACTION_BITS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 load,
   input  logic                                 item_valid,
   input  logic signed [SAMPLE_BITS-1:0]        sample,
   input  logic [aiec_pkg::AXIS_BITS-1:0]       axis,
   input  logic                                 no_reading,
   input  logic [aiec_pkg::WARMUP_BITS-1:0]     warmup_triples,
   output aiec_pkg::stage_ctl_type              ctl_ff,
   output logic [2:0][DEV_BITS-1:0]             dev_ff
);

   localparam int FW = DEV_BITS;
   localparam int SHIFT = FW + 4;
   localparam int PW = 2 * FW + 2;
   // ceil(2^SHIFT / divisor): exact quotient for magnitudes below 2^(FW+1)
   localparam logic [PW-1:0] RECIP_WIDE =
      ((PW'(1) << SHIFT) + PW'(aiec_pkg::FILTER_DIVISOR - 1)) /
      PW'(aiec_pkg::FILTER_DIVISOR);
   localparam logic [FW:0] RECIP = RECIP_WIDE[FW:0];

   logic [2:0][SAMPLE_BITS-1:0]        pend_ff, pend_in;
   logic [2:0]                         pvalid_ff, pvalid_in;
   logic [2:0][FW-1:0]                 lp_ff, lp_in;
   logic [aiec_pkg::WARMUP_BITS-1:0]   wc_ff, wc_in;
   aiec_pkg::stage_ctl_type            ctl_in;
   logic [2:0][FW-1:0]                 dev_in;

   logic                               use_sample;
   logic                               complete;
   logic [2:0][FW-1:0]                 target;
   logic [2:0][FW:0]                   err;
   logic [2:0][FW:0]                   err_mag;
   logic [2:0][PW-1:0]                 prod;
   logic [2:0][FW:0]                   quot;
   logic [2:0][FW:0]                   step;
   logic [2:0][FW:0]                   lp_sum;
   logic [2:0][FW:0]                   dev_mag;

   // Per-axis filter arithmetic on the updated pending triple
   always_comb begin
      for (int k = 0; k < aiec_pkg::AXIS_COUNT; k++) begin
         target[k]  = {pend_in[k], {FILTER_FRACTION_BITS{1'b0}}};
         err[k]     = {target[k][FW-1], target[k]} - {lp_ff[k][FW-1], lp_ff[k]};
         err_mag[k] = err[k][FW] ? (~err[k] + 1'b1) : err[k];
         prod[k]    = PW'(err_mag[k]) * PW'(RECIP);
         quot[k]    = (FW+1)'(prod[k][PW-1:SHIFT]);
         step[k]    = err[k][FW] ? (~quot[k] + 1'b1) : quot[k];
         lp_sum[k]  = {lp_ff[k][FW-1], lp_ff[k]} + step[k];
         dev_mag[k] = err_mag[k] - quot[k];
         dev_in[k]  = dev_mag[k][FW-1:0];
      end
   end

   always_comb begin
      use_sample = item_valid && !no_reading && (axis <= aiec_pkg::AXIS_Z);
      pend_in = pend_ff;
      pvalid_in = pvalid_ff;
      if (use_sample) begin
         pend_in[axis] = sample;
         pvalid_in[axis] = 1'b1;
      end
      complete = use_sample && (pvalid_in == 3'b111);
      lp_in = lp_ff;
      wc_in = wc_ff;
      ctl_in.valid = item_valid;
      ctl_in.search = 1'b0;
      if (complete) begin
         for (int k = 0; k < aiec_pkg::AXIS_COUNT; k++) begin
            lp_in[k] = lp_sum[k][FW-1:0];
         end
         pvalid_in = 3'b000;
         if (wc_ff < warmup_triples) begin
            wc_in = wc_ff + 1'b1;
         end else begin
            ctl_in.search = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pvalid_ff <= '0;
         lp_ff <= '0;
         wc_ff <= '0;
         ctl_ff <= '0;
      end else if (load) begin
         pvalid_ff <= pvalid_in;
         lp_ff <= lp_in;
         wc_ff <= wc_in;
         ctl_ff <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         pend_ff <= pend_in;
         dev_ff <= dev_in;
      end
   end

   // A full triple is always consumed in the cycle it completes
   assert property (@(posedge clock) disable iff (reset) pvalid_ff != 3'b111)
      else $error("pending triple left full");

   assert property (@(posedge clock) disable iff (reset)
      ctl_ff.search |-> ctl_ff.valid)
      else $error("search flagged on an empty stage");

   assert property (@(posedge clock) disable iff (reset)
      (load && use_sample) |=>
         (pvalid_ff[$past(axis)] || (pvalid_ff == 3'b000)))
      else $error("accepted sample not held");

endmodule

FILE: hw/rtl/aiec_square.sv
// Squaring stage: squares the three deviation magnitudes.
// Depends on aiec_pkg for the stage control type.

module aiec_square #(
   parameter int DEV_BITS = 24
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              load,
   input  aiec_pkg::stage_ctl_type           ctl_i,
   input  logic [2:0][DEV_BITS-1:0]          dev_i,
   output aiec_pkg::stage_ctl_type           ctl_ff,
   output logic [2:0][2*DEV_BITS-1:0]        sq_ff
);

   logic [2:0][2*DEV_BITS-1:0] sq_in;

   always_comb begin
      for (int k = 0; k < aiec_pkg::AXIS_COUNT; k++) begin
         sq_in[k] = (2*DEV_BITS)'(dev_i[k]) * (2*DEV_BITS)'(dev_i[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (load) begin
         ctl_ff <= ctl_i;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         sq_ff <= sq_in;
      end
   end

endmodule

FILE: hw/rtl/aiec_detect.sv
// Threshold compare, hysteresis counter and impact total; drives the
// response register. Depends on aiec_pkg.

module aiec_detect #(
   parameter int DEV_BITS = 24,
   parameter int FILTER_FRACTION_BITS = 8
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   load,
   input  aiec_pkg::stage_ctl_type                ctl_i,
   input  logic [2:0][2*DEV_BITS-1:0]             sq_i,
   input  logic [aiec_pkg::THRESHOLD_BITS-1:0]    threshold,
   input  logic [aiec_pkg::OVER_LIMIT_BITS-1:0]   over_limit,
   output logic                                   rsp_valid_ff,
   output logic [aiec_pkg::COUNT_BITS-1:0]        count_ff,
   output logic                                   new_ff
);

   localparam int TW = aiec_pkg::THRESHOLD_BITS + FILTER_FRACTION_BITS;
   localparam int SW = 2 * DEV_BITS + 2;
   localparam int CW = (SW > 2 * TW) ? SW : 2 * TW;
   localparam int OCW = aiec_pkg::OVER_COUNT_BITS;

   logic [TW-1:0]                      thr;
   logic [2*TW-1:0]                    thr_sq_ff;
   logic [SW-1:0]                      sum;
   logic                               over;
   logic [OCW-1:0]                     limit;
   logic [OCW-1:0]                     oc_up;
   logic                               fresh;

   logic [OCW-1:0]                     oc_ff, oc_in;
   logic                               armed_ff, armed_in;
   logic [aiec_pkg::COUNT_BITS-1:0]    total_ff, total_in;

   assign thr = {threshold, {FILTER_FRACTION_BITS{1'b0}}};

   // Follows the threshold register; the user must change it only while the block is idle (not enforced)
   always_ff @(posedge clock) begin
      thr_sq_ff <= (2*TW)'(thr) * (2*TW)'(thr);
   end

   always_comb begin
      sum = SW'(sq_i[0]) + SW'(sq_i[1]) + SW'(sq_i[2]);
      over = CW'(sum) >= CW'(thr_sq_ff);
      limit = {1'b0, over_limit};
      oc_up = (oc_ff <= limit) ? OCW'(oc_ff + 1'b1) : oc_ff;
      oc_in = oc_ff;
      armed_in = armed_ff;
      total_in = total_ff;
      fresh = 1'b0;
      if (ctl_i.valid && ctl_i.search) begin
         if (over) begin
            oc_in = oc_up;
            if ((oc_up > limit) && armed_ff) begin
               fresh = 1'b1;
               armed_in = 1'b0;
               if (total_ff != aiec_pkg::COUNT_MAX) begin
                  total_in = total_ff + 1'b1;
               end
            end
         end else if (oc_ff != '0) begin
            oc_in = OCW'(oc_ff - 1'b1);
            // re-arm once the count drains back to zero
            if (oc_in == '0) begin
               armed_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         oc_ff <= '0;
         armed_ff <= 1'b1;
         total_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (load) begin
         oc_ff <= oc_in;
         armed_ff <= armed_in;
         total_ff <= total_in;
         rsp_valid_ff <= ctl_i.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         count_ff <= total_in;
         new_ff <= fresh;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      oc_ff <= aiec_pkg::OVER_COUNT_CEILING)
      else $error("over count beyond ceiling");

   assert property (@(posedge clock) disable iff (reset)
      !armed_ff |-> (oc_ff != '0))
      else $error("disarmed with empty over count");

   assert property (@(posedge clock) disable iff (reset)
      (load && fresh) |=> (!armed_ff && new_ff && rsp_valid_ff))
      else $error("impact not reported or not disarmed");

   assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> (total_ff >= $past(total_ff)))
      else $error("impact total decreased");

endmodule

FILE: hw/rtl/accel_impact_event_counter.sv
// Impact event counter: per-axis accelerometer samples in, impact count out.
// Depends on aiec_pkg, aiec_ifs, aiec_filter, aiec_square and aiec_detect.
//
// Each request carries one axis sample; x, y and z are gathered into a
// triple, and a full triple steps three low-pass filters by one tenth of the
// error and, after the warm-up triples, tests the squared deviation against
// the squared threshold to drive a hysteresis counter that registers impacts.
// Every request yields exactly one response with the running impact count.
// The block accepts one request per clock while responses are taken, and
// presents its response through four registers: an input register, the
// filter stage (one reciprocal multiply per axis), the squaring stage (one
// multiplier per axis) and the compare/count stage that loads the response
// register. Each register stage holds its contents while the stage after it
// is full and held, so up to four requests are held while a response waits
// before the request side stalls. Register writes are taken at once and must
// be made while no request is in flight.

module accel_impact_event_counter #(
   parameter int SAMPLE_BITS = 16,
   parameter int FILTER_FRACTION_BITS = 8
) (
   input  logic        clock,
   input  logic        reset,
   aiec_req_if.sink    req_bus,
   aiec_rsp_if.source  rsp_bus,
   aiec_csr_if.sink    csr_bus
);

   localparam int DEV_BITS = SAMPLE_BITS + FILTER_FRACTION_BITS;

   logic [aiec_pkg::THRESHOLD_BITS-1:0]    threshold_ff;
   logic [aiec_pkg::OVER_LIMIT_BITS-1:0]   over_limit_ff;
   logic [aiec_pkg::WARMUP_BITS-1:0]       warmup_ff;

   logic                                   in_valid_ff;
   logic signed [SAMPLE_BITS-1:0]          in_sample_ff;
   logic [aiec_pkg::AXIS_BITS-1:0]         in_axis_ff;
   logic                                   in_no_reading_ff;

   aiec_pkg::stage_ctl_type                filt_ctl;
   logic [2:0][DEV_BITS-1:0]               filt_dev;
   aiec_pkg::stage_ctl_type                sq_ctl;
   logic [2:0][2*DEV_BITS-1:0]             sq_val;
   logic                                   rsp_valid;

   logic                                   en_in, en_filt, en_sq, en_det;

   // Each stage loads when it is empty or its contents move on
   assign en_det  = !rsp_valid || rsp_bus.ready;
   assign en_sq   = !sq_ctl.valid || en_det;
   assign en_filt = !filt_ctl.valid || en_sq;
   assign en_in   = !in_valid_ff || en_filt;

   assign req_bus.ready = en_in;
   assign csr_bus.ready = 1'b1;
   assign rsp_bus.valid = rsp_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= aiec_pkg::THRESHOLD_RESET;
         over_limit_ff <= aiec_pkg::OVER_LIMIT_RESET;
         warmup_ff <= aiec_pkg::WARMUP_RESET;
      end else if (csr_bus.valid) begin
         unique case (csr_bus.index)
            aiec_pkg::CSR_IMPACT_THRESHOLD: begin
               threshold_ff <= csr_bus.data[aiec_pkg::THRESHOLD_BITS-1:0];
            end
            aiec_pkg::CSR_OVER_LIMIT: begin
               over_limit_ff <= csr_bus.data[aiec_pkg::OVER_LIMIT_BITS-1:0];
            end
            aiec_pkg::CSR_WARMUP_TRIPLES: begin
               warmup_ff <= csr_bus.data[aiec_pkg::WARMUP_BITS-1:0];
            end
            default: begin
               // drop writes to unknown indexes
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (en_in) begin
         in_valid_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en_in && req_bus.valid) begin
         in_sample_ff <= req_bus.sample;
         in_axis_ff <= req_bus.axis;
         in_no_reading_ff <= req_bus.no_reading;
      end
   end

   aiec_filter #(
      .SAMPLE_BITS(SAMPLE_BITS),
      .FILTER_FRACTION_BITS(FILTER_FRACTION_BITS),
      .DEV_BITS(DEV_BITS)
   ) u_filter (
      .clock(clock),
      .reset(reset),
      .load(en_filt),
      .item_valid(in_valid_ff),
      .sample(in_sample_ff),
      .axis(in_axis_ff),
      .no_reading(in_no_reading_ff),
      .warmup_triples(warmup_ff),
      .ctl_ff(filt_ctl),
      .dev_ff(filt_dev)
   );

   aiec_square #(
      .DEV_BITS(DEV_BITS)
   ) u_square (
      .clock(clock),
      .reset(reset),
      .load(en_sq),
      .ctl_i(filt_ctl),
      .dev_i(filt_dev),
      .ctl_ff(sq_ctl),
      .sq_ff(sq_val)
   );

   aiec_detect #(
      .DEV_BITS(DEV_BITS),
      .FILTER_FRACTION_BITS(FILTER_FRACTION_BITS)
   ) u_detect (
      .clock(clock),
      .reset(reset),
      .load(en_det),
      .ctl_i(sq_ctl),
      .sq_i(sq_val),
      .threshold(threshold_ff),
      .over_limit(over_limit_ff),
      .rsp_valid_ff(rsp_valid),
      .count_ff(rsp_bus.impact_count),
      .new_ff(rsp_bus.new_impact)
   );

endmodule

FILE: bench/aiec_checker.sv
// Response checker for the impact event counter: predicts each response from
// the accepted requests and register writes, then compares in order.
// Depends on aiec_pkg and the channel interfaces in aiec_ifs.

module aiec_checker #(
   parameter int SAMPLE_BITS = 16,
   parameter int FILTER_FRACTION_BITS = 8
) (
   input  logic        clock,
   input  logic        reset,
   aiec_req_if         req_bus,
   aiec_rsp_if         rsp_bus,
   aiec_csr_if         csr_bus,
   output int unsigned error_count,
   output int unsigned outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [aiec_pkg::COUNT_BITS-1:0] impact_count;
      logic                            new_impact;
   } impact_report_type;

   impact_report_type pending_reports[$];

   logic [aiec_pkg::THRESHOLD_BITS-1:0]  threshold_cfg;
   logic [aiec_pkg::OVER_LIMIT_BITS-1:0] over_limit_cfg;
   logic [aiec_pkg::WARMUP_BITS-1:0]     warmup_cfg;

   logic signed [SAMPLE_BITS-1:0]         held_sample [aiec_pkg::AXIS_COUNT];
   logic [aiec_pkg::AXIS_COUNT-1:0]       held_mask;
   longint                                lp_level [aiec_pkg::AXIS_COUNT];
   int unsigned                           warmup_count;
   int unsigned                           over_count;
   int unsigned                           impact_total;
   bit                                    armed;

   // Advance the detector by one request and return the response it yields.
   function automatic impact_report_type detect_impact(
      input logic signed [SAMPLE_BITS-1:0]     sample,
      input logic [aiec_pkg::AXIS_BITS-1:0]    axis,
      input logic                              no_reading
   );
      impact_report_type report;
      longint target;
      longint dev;
      longint unsigned energy;
      longint unsigned bound;
      bit fresh;
      int k;
      fresh = 1'b0;
      if (!no_reading && int'(axis) < aiec_pkg::AXIS_COUNT) begin
         held_sample[axis] = sample;
         held_mask[axis] = 1'b1;
         if (&held_mask) begin
            held_mask = '0;
            for (k = 0; k < aiec_pkg::AXIS_COUNT; k++) begin
               target = longint'(held_sample[k]) * (longint'(1) << FILTER_FRACTION_BITS);
               // signed division truncates toward zero
               lp_level[k] = lp_level[k] +
                             (target - lp_level[k]) / aiec_pkg::FILTER_DIVISOR;
            end
            if (warmup_count < warmup_cfg) begin
               warmup_count++;
            end else begin
               energy = 0;
               for (k = 0; k < aiec_pkg::AXIS_COUNT; k++) begin
                  dev = longint'(held_sample[k]) * (longint'(1) << FILTER_FRACTION_BITS)
                        - lp_level[k];
                  if (dev < 0) dev = -dev;
                  energy += longint'(unsigned'(dev)) * longint'(unsigned'(dev));
               end
               bound = longint'(threshold_cfg) << FILTER_FRACTION_BITS;
               bound = bound * bound;
               if (energy >= bound) begin
                  if (over_count <= over_limit_cfg) over_count++;
                  if (over_count > over_limit_cfg && armed) begin
                     armed = 1'b0;
                     fresh = 1'b1;
                     if (impact_total < aiec_pkg::COUNT_MAX) impact_total++;
                  end
               end else if (over_count > 0) begin
                  over_count--;
                  if (over_count == 0) armed = 1'b1;
               end
            end
         end
      end
      report.impact_count = impact_total[aiec_pkg::COUNT_BITS-1:0];
      report.new_impact = fresh;
      return report;
   endfunction

   always @(posedge clock) begin
      impact_report_type want;
      int k;
      if (reset) begin
         threshold_cfg = aiec_pkg::THRESHOLD_RESET;
         over_limit_cfg = aiec_pkg::OVER_LIMIT_RESET;
         warmup_cfg = aiec_pkg::WARMUP_RESET;
         for (k = 0; k < aiec_pkg::AXIS_COUNT; k++) begin
            held_sample[k] = '0;
            lp_level[k] = 0;
         end
         held_mask = '0;
         warmup_count = 0;
         over_count = 0;
         impact_total = 0;
         armed = 1'b1;
         pending_reports.delete();
         error_count = 0;
      end else begin
         // retire before predicting: a response never belongs to a request of the same edge
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (pending_reports.size() == 0) begin
               $error("unexpected response: impact_count %0d new_impact %0b",
                      rsp_bus.impact_count, rsp_bus.new_impact);
               error_count++;
            end else begin
               want = pending_reports.pop_front();
               if (rsp_bus.impact_count !== want.impact_count) begin
                  $error("impact_count mismatch: expected %0d, got %0d",
                         want.impact_count, rsp_bus.impact_count);
                  error_count++;
               end
               if (rsp_bus.new_impact !== want.new_impact) begin
                  $error("new_impact mismatch: expected %0b, got %0b",
                         want.new_impact, rsp_bus.new_impact);
                  error_count++;
               end
            end
         end
         if (csr_bus.valid && csr_bus.ready) begin
            case (csr_bus.index)
               aiec_pkg::CSR_IMPACT_THRESHOLD:
                  threshold_cfg = csr_bus.data[aiec_pkg::THRESHOLD_BITS-1:0];
               aiec_pkg::CSR_OVER_LIMIT:
                  over_limit_cfg = csr_bus.data[aiec_pkg::OVER_LIMIT_BITS-1:0];
               aiec_pkg::CSR_WARMUP_TRIPLES:
                  warmup_cfg = csr_bus.data[aiec_pkg::WARMUP_BITS-1:0];
               default: ;
            endcase
         end
         if (req_bus.valid && req_bus.ready) begin
            pending_reports.push_back(detect_impact(req_bus.sample, req_bus.axis,
                                                    req_bus.no_reading));
         end
      end
      outstanding <= pending_reports.size();
   end

endmodule

FILE: bench/accel_impact_event_counter_test.sv
// Top of the impact event counter bench: clock, reset, request and register
// stimulus, response back-pressure, watchdog and verdict.
// Depends on aiec_pkg, aiec_ifs, the block itself and aiec_checker.

module accel_impact_event_counter_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SAMPLE_BITS = 16;
   localparam int FILTER_FRACTION_BITS = 8;
   localparam logic [aiec_pkg::AXIS_BITS-1:0] AXIS_NONE = 2'd3;
   localparam int unsigned WATCHDOG_LIMIT = 3000;
   localparam int unsigned RSP_HOLD_CYCLES = 80;
   localparam int unsigned SETTLE_CYCLES = 8;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int unsigned failures;
   int unsigned outstanding;
   int unsigned idle_cycles = 0;
   bit steady = 1'b0;
   bit rsp_hold_req = 1'b0;
   bit rsp_hold_done = 1'b0;

   aiec_req_if #(.SAMPLE_BITS(SAMPLE_BITS)) req_bus ();
   aiec_rsp_if rsp_bus ();
   aiec_csr_if csr_bus ();

   accel_impact_event_counter #(
      .SAMPLE_BITS(SAMPLE_BITS),
      .FILTER_FRACTION_BITS(FILTER_FRACTION_BITS)
   ) u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   aiec_checker #(
      .SAMPLE_BITS(SAMPLE_BITS),
      .FILTER_FRACTION_BITS(FILTER_FRACTION_BITS)
   ) u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_bus     (csr_bus),
      .error_count (failures),
      .outstanding (outstanding)
   );

   always #5 clock = ~clock;

   function automatic logic [aiec_pkg::AXIS_BITS-1:0] axis_code(input int unsigned slot);
      case (slot)
         0: return aiec_pkg::AXIS_X;
         1: return aiec_pkg::AXIS_Y;
         default: return aiec_pkg::AXIS_Z;
      endcase
   endfunction

   // Mostly no gap, sometimes a short one, rarely a long one.
   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 65) return 0;
      if (roll < 93) return $urandom_range(3, 1);
      return $urandom_range(40, 8);
   endfunction

   function automatic logic signed [SAMPLE_BITS-1:0] make_sample(input int centre,
                                                                 input bit burst);
      int value;
      if (burst) return SAMPLE_BITS'($urandom);
      value = centre + int'($urandom_range(128)) - 64;
      if (value > 32767) value = 32767;
      if (value < -32768) value = -32768;
      return SAMPLE_BITS'(value);
   endfunction

   // Offer one request, hold it until taken, then maybe idle.
   task automatic push_request(input logic signed [SAMPLE_BITS-1:0] sample,
                               input logic [aiec_pkg::AXIS_BITS-1:0] axis,
                               input logic no_reading);
      int unsigned gap;
      req_bus.sample <= sample;
      req_bus.axis <= axis;
      req_bus.no_reading <= no_reading;
      req_bus.valid <= 1'b1;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      gap = steady ? 0 : pick_gap();
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_triple(input int x, input int y, input int z);
      push_request(SAMPLE_BITS'(x), aiec_pkg::AXIS_X, 1'b0);
      push_request(SAMPLE_BITS'(y), aiec_pkg::AXIS_Y, 1'b0);
      push_request(SAMPLE_BITS'(z), aiec_pkg::AXIS_Z, 1'b0);
   endtask

   // Stop offering and wait until every response is back.
   task automatic drain();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   task automatic write_reg(input logic [aiec_pkg::CSR_INDEX_BITS-1:0] index,
                            input logic [aiec_pkg::CSR_DATA_BITS-1:0] value);
      csr_bus.index <= index;
      csr_bus.data <= value;
      csr_bus.valid <= 1'b1;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
   endtask

   task automatic apply_config(input logic [aiec_pkg::THRESHOLD_BITS-1:0] threshold,
                               input logic [aiec_pkg::OVER_LIMIT_BITS-1:0] over_limit,
                               input logic [aiec_pkg::WARMUP_BITS-1:0] warmup);
      drain();
      write_reg(aiec_pkg::CSR_IMPACT_THRESHOLD, aiec_pkg::CSR_DATA_BITS'(threshold));
      write_reg(aiec_pkg::CSR_OVER_LIMIT, aiec_pkg::CSR_DATA_BITS'(over_limit));
      write_reg(aiec_pkg::CSR_WARMUP_TRIPLES, aiec_pkg::CSR_DATA_BITS'(warmup));
      csr_bus.valid <= 1'b0;
   endtask

   // Mostly complete triples around a drifting baseline with occasional bursts
   // of full-range samples; the rest is invalid, unused-axis and stray samples.
   task automatic play_phase(input int unsigned budget);
      int unsigned done;
      int unsigned burst_left;
      int unsigned first;
      int unsigned slot;
      bit swap;
      int centre [aiec_pkg::AXIS_COUNT];
      int k;
      done = 0;
      burst_left = 0;
      for (k = 0; k < aiec_pkg::AXIS_COUNT; k++) begin
         centre[k] = int'($urandom_range(16000)) - 8000;
      end
      while (done < budget) begin
         if ($urandom_range(99) < 85) begin
            if (burst_left == 0 && $urandom_range(11) == 0) burst_left = $urandom_range(6, 1);
            first = $urandom_range(2);
            swap = $urandom_range(1);
            for (k = 0; k < aiec_pkg::AXIS_COUNT; k++) begin
               slot = (first + (swap ? 3 - k : k)) % 3;
               push_request(make_sample(centre[slot], burst_left != 0), axis_code(slot), 1'b0);
            end
            if (burst_left != 0) burst_left--;
            done += 3;
         end else begin
            case ($urandom_range(2))
               0: push_request(SAMPLE_BITS'($urandom),
                               ($urandom_range(3) == 3) ? AXIS_NONE
                                                        : axis_code($urandom_range(2)),
                               1'b1);
               1: push_request(SAMPLE_BITS'($urandom), AXIS_NONE, 1'b0);
               default: begin
                  slot = $urandom_range(2);
                  push_request(make_sample(centre[slot], 1'b0), axis_code(slot), 1'b0);
                  done++;
               end
            endcase
         end
         if ($urandom_range(49) == 0) begin
            for (k = 0; k < aiec_pkg::AXIS_COUNT; k++) begin
               centre[k] = int'($urandom_range(16000)) - 8000;
            end
         end
      end
   endtask

   initial begin
      req_bus.valid <= 1'b0;
      req_bus.sample <= '0;
      req_bus.axis <= aiec_pkg::AXIS_X;
      req_bus.no_reading <= 1'b0;
      csr_bus.valid <= 1'b0;
      csr_bus.index <= aiec_pkg::CSR_IMPACT_THRESHOLD;
      csr_bus.data <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // reset configuration: every triple is warm-up
      send_triple(-32768, 32767, 0);
      push_request(16'sh7FFF, aiec_pkg::AXIS_X, 1'b1);
      push_request(16'sh8000, AXIS_NONE, 1'b0);
      push_request(16'sd1, aiec_pkg::AXIS_X, 1'b0);
      push_request(-16'sd1, aiec_pkg::AXIS_X, 1'b0);
      push_request(16'sh5555, aiec_pkg::AXIS_Y, 1'b0);
      push_request(16'shAAAA, aiec_pkg::AXIS_Z, 1'b0);
      push_request(16'sh0, AXIS_NONE, 1'b1);
      send_triple(100, 200, 300);
      // warm-up now below the count reached: search starts on the next triple
      apply_config(16'd0, 8'd0, 7'd1);
      send_triple(-32768, -32768, -32768);
      send_triple(32767, 32767, 32767);
      // nothing reaches the top threshold: count falls back and re-arms
      apply_config(16'hFFFF, 8'd0, 7'd1);
      send_triple(0, 0, 0);
      apply_config(16'd0, 8'd0, 7'd1);
      send_triple(-1, 0, 1);

      // long response hold-off while requests keep coming
      apply_config(16'd1500, 8'd2, 7'd5);
      steady = 1'b1;
      rsp_hold_req = 1'b1;
      play_phase(200);

      // every triple over threshold: counter climbs toward its ceiling
      apply_config(16'd0, 8'hFF, 7'd0);
      steady = ($urandom_range(3) == 0);
      play_phase(750);

      apply_config(16'hFFFF, 8'd0, 7'h7F);
      steady = ($urandom_range(3) == 0);
      play_phase(420);

      repeat (3) begin
         apply_config(aiec_pkg::THRESHOLD_BITS'($urandom_range(4000, 200)),
                      aiec_pkg::OVER_LIMIT_BITS'($urandom_range(4)),
                      aiec_pkg::WARMUP_BITS'($urandom_range(10)));
         steady = ($urandom_range(3) == 0);
         play_phase(120);
      end

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (failures == 0 && outstanding == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   initial begin
      int unsigned run_len;
      int unsigned stall_len;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (rsp_hold_req && !rsp_hold_done) begin
            // hold long enough for the pipeline to back up into the request side
            rsp_bus.ready <= 1'b0;
            repeat (RSP_HOLD_CYCLES) @(posedge clock);
            rsp_hold_done = 1'b1;
         end
         rsp_bus.ready <= 1'b1;
         run_len = ($urandom_range(19) == 0) ? $urandom_range(150, 40) : $urandom_range(8, 1);
         repeat (run_len) @(posedge clock);
         stall_len = pick_gap();
         if (stall_len != 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall_len) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule

FILE: files.f
hw/rtl/aiec_pkg.sv
hw/rtl/aiec_ifs.sv
hw/rtl/aiec_filter.sv
hw/rtl/aiec_square.sv
hw/rtl/aiec_detect.sv
hw/rtl/accel_impact_event_counter.sv
bench/aiec_checker.sv
bench/accel_impact_event_counter_test.sv
